// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the tracker pattern unpacker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, disabled while reset is high.
`define TPU_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Checked property, also evaluated during reset.
`define TPU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ===== hw/rtl/tpu_pkg.sv =====
// Types, phase codes and helper functions of the tracker pattern unpacker.
package tpu_pkg;

  localparam int MAX_CHANNELS = 64;
  localparam int CH_W         = $clog2(MAX_CHANNELS);

  // parse phases
  localparam logic [2:0] PH_CHAN   = 3'd0;
  localparam logic [2:0] PH_MASK   = 3'd1;
  localparam logic [2:0] PH_NOTE   = 3'd2;
  localparam logic [2:0] PH_INSTR  = 3'd3;
  localparam logic [2:0] PH_VOLPAN = 3'd4;
  localparam logic [2:0] PH_CMD    = 3'd5;
  localparam logic [2:0] PH_CMDVAL = 3'd6;
  localparam logic [2:0] PH_APPLY  = 3'd7;  // mask read in flight

  localparam logic [7:0] NOTE_PAUSE = 8'd254;
  localparam logic [7:0] MASK_NOTE   = 8'h11;
  localparam logic [7:0] MASK_INSTR  = 8'h22;
  localparam logic [7:0] MASK_VOLPAN = 8'h44;
  localparam logic [7:0] MASK_CMD    = 8'h88;

  typedef struct packed {
    logic [3:0] flags;   // bit 0 note, 1 instr, 2 volpan, 3 command
    logic [7:0] note;
    logic [7:0] instr;
    logic [7:0] volpan;
    logic [7:0] code;
    logic [7:0] arg;
  } chan_rec_t;

  localparam chan_rec_t REC_RESET = '{
    flags:  4'b0001,
    note:   NOTE_PAUSE,
    instr:  8'h00,
    volpan: 8'h00,
    code:   8'h00,
    arg:    8'h00
  };

  // first fetch phase at or after 'from' with its mask bit set, else PH_CHAN
  function automatic logic [2:0] fetch_after(input logic [7:0] mask,
                                             input logic [2:0] from);
    logic [2:0] ph;
    ph = PH_CHAN;
    for (int p = 5; p >= 2; p--) begin
      if (3'(p) >= from && mask[p - 2]) ph = 3'(p);
    end
    return ph;
  endfunction

  function automatic logic [3:0] flag_bits(input logic [7:0] mask);
    return {|(mask & MASK_CMD), |(mask & MASK_VOLPAN),
            |(mask & MASK_INSTR), |(mask & MASK_NOTE)};
  endfunction

endpackage

// ===== hw/rtl/tpu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/tpu_front.sv =====
// Byte parser: channel masks, per-channel values and flags, row records.
module tpu_front #(
  parameter int OUT_CHANNELS = 5
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [7:0]                                 data_byte,
  input  logic                                       pattern_start,
  input  logic [15:0]                                row_count,
  output logic                                       push,
  output logic [OUT_CHANNELS*$bits(tpu_pkg::chan_rec_t):0] push_data,
  input  logic                                       q_full
);
  import tpu_pkg::*;

  localparam int KW = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;

  logic [2:0]        phase, phase_next;
  logic [CH_W-1:0]   cur_ch, cur_ch_next;
  logic [7:0]        cur_mask, cur_mask_next;
  logic [15:0]       rows_done, rows_next;
  logic [MAX_CHANNELS-1:0] mask_vld, mask_vld_next;
  chan_rec_t [OUT_CHANNELS-1:0] recs, recs_next;
  logic              rd_vld, rd_vld_next;

  logic              acc;
  logic [2:0]        phase_v, ph_eff;
  logic [15:0]       rows_v;
  logic [MAX_CHANNELS-1:0] vld_v;
  chan_rec_t [OUT_CHANNELS-1:0] recs_v, recs_a;
  logic [7:0]        rd_data, m_eff, mask_use;
  logic              active, cur_in, last_row;
  logic              ram_we, ram_re;
  logic [CH_W-1:0]   ram_raddr;
  logic [KW-1:0]     cur_k;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  assign m_eff    = rd_vld ? rd_data : 8'h00;
  assign cur_in   = cur_ch < CH_W'(OUT_CHANNELS);
  assign cur_k    = cur_ch[KW-1:0];
  assign last_row = (17'(rows_v) + 17'd1) == 17'(row_count);
  assign ram_raddr = CH_W'(data_byte - 8'd1);

  always_comb begin
    phase_v = pattern_start ? PH_CHAN : phase;
    rows_v  = pattern_start ? 16'd0 : rows_done;
    vld_v   = pattern_start ? '0 : mask_vld;
    for (int k = 0; k < OUT_CHANNELS; k++) begin
      recs_v[k] = pattern_start ? REC_RESET : recs[k];
    end
    active   = rows_v < row_count;
    ph_eff   = (phase_v == PH_APPLY) ? fetch_after(m_eff, PH_NOTE) : phase_v;
    mask_use = (phase_v == PH_APPLY) ? m_eff : cur_mask;
    recs_a   = recs_v;
    if (phase_v == PH_APPLY && cur_in) begin
      recs_a[cur_k].flags = flag_bits(m_eff);
    end

    phase_next    = phase;
    cur_ch_next   = cur_ch;
    cur_mask_next = cur_mask;
    rows_next     = rows_done;
    mask_vld_next = mask_vld;
    recs_next     = recs;
    rd_vld_next   = rd_vld;
    push          = 1'b0;
    push_data     = {last_row, recs_a};
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    if (acc) begin
      phase_next    = phase_v;
      cur_ch_next   = pattern_start ? '0 : cur_ch;
      rows_next     = rows_v;
      mask_vld_next = vld_v;
      recs_next     = recs_v;
      if (active) begin
        recs_next     = recs_a;
        cur_mask_next = mask_use;
        phase_next    = ph_eff;
        unique case (ph_eff) inside
          PH_CHAN: begin
            if (data_byte == 8'h00) begin
              push      = 1'b1;
              rows_next = rows_v + 16'd1;
              for (int k = 0; k < OUT_CHANNELS; k++) begin
                recs_next[k].flags = 4'b0000;
              end
            end else begin
              cur_ch_next = ram_raddr;
              ram_re      = 1'b1;
              rd_vld_next = vld_v[ram_raddr];
              phase_next  = data_byte[7] ? PH_MASK : PH_APPLY;
            end
          end
          PH_MASK: begin
            ram_we                = 1'b1;
            mask_vld_next[cur_ch] = 1'b1;
            cur_mask_next         = data_byte;
            if (cur_in) begin
              recs_next[cur_k].flags = flag_bits(data_byte);
            end
            phase_next = fetch_after(data_byte, PH_NOTE);
          end
          PH_NOTE, PH_INSTR, PH_VOLPAN, PH_CMD, PH_CMDVAL: begin
            if (cur_in) begin
              case (ph_eff)
                PH_NOTE:   recs_next[cur_k].note   = data_byte;
                PH_INSTR:  recs_next[cur_k].instr  = data_byte;
                PH_VOLPAN: recs_next[cur_k].volpan = data_byte;
                PH_CMD:    recs_next[cur_k].code   = data_byte;
                default:   recs_next[cur_k].arg    = data_byte;
              endcase
            end
            if (ph_eff == PH_CMD) begin
              phase_next = PH_CMDVAL;
            end else if (ph_eff == PH_CMDVAL) begin
              phase_next = PH_CHAN;
            end else begin
              phase_next = fetch_after(mask_use, ph_eff + 3'd1);
            end
          end
          default: begin
            phase_next = PH_CHAN;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CHAN;
      cur_ch    <= '0;
      cur_mask  <= 8'h00;
      rows_done <= 16'd0;
      mask_vld  <= '0;
      rd_vld    <= 1'b0;
      for (int k = 0; k < OUT_CHANNELS; k++) begin
        recs[k] <= REC_RESET;
      end
    end else begin
      phase     <= phase_next;
      cur_ch    <= cur_ch_next;
      cur_mask  <= cur_mask_next;
      rows_done <= rows_next;
      mask_vld  <= mask_vld_next;
      rd_vld    <= rd_vld_next;
      recs      <= recs_next;
    end
  end

  tpu_ram #(
    .WIDTH (8),
    .DEPTH (MAX_CHANNELS)
  ) u_mask_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_ch),
    .wdata (data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

endmodule

// ===== hw/rtl/tpu_queue.sv =====
// Two-entry queue of row records between parser and result sequencer.
`include "assert_macros.svh"

module tpu_queue #(
  parameter int WIDTH = 221
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `TPU_ASSERT(a_no_push_full, clk, rst, full |-> !push)
  `TPU_ASSERT(a_no_pop_empty, clk, rst, !not_empty |-> !pop)
  `TPU_ASSERT_ALWAYS(a_count_range, clk, rst || count != 2'd3)

endmodule

// ===== hw/rtl/tpu_back.sv =====
// Result sequencer: expands a row record into one transfer per channel.
`include "assert_macros.svh"

module tpu_back #(
  parameter int OUT_CHANNELS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [OUT_CHANNELS*$bits(tpu_pkg::chan_rec_t):0] pop_data,
  input  logic        not_empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_data,
  output logic        out_last,
  output logic        out_user
);
  import tpu_pkg::*;

  localparam int KW = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
  localparam logic [KW-1:0] KLAST = KW'(OUT_CHANNELS - 1);

  chan_rec_t [OUT_CHANNELS-1:0] row_q, row_in;
  logic                         last_q;
  logic                         busy;
  logic [KW-1:0]                k;
  logic                         adv;
  chan_rec_t                    cur;

  assign row_in = pop_data[OUT_CHANNELS*$bits(chan_rec_t)-1:0];
  assign adv    = !out_valid || out_ready;
  assign pop    = not_empty && (!busy || (adv && k == KLAST));
  assign cur    = row_q[k];

  always_ff @(posedge clk) begin
    if (busy && adv) begin
      out_data <= {1'b0, cur.arg, cur.code, cur.flags[3], cur.volpan, cur.flags[2],
                   cur.instr, cur.flags[1], cur.note, cur.flags[0], 3'(k)};
      out_last <= k == KLAST;
      out_user <= last_q;
    end
    if (pop) begin
      row_q  <= row_in;
      last_q <= pop_data[OUT_CHANNELS*$bits(chan_rec_t)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      busy      <= 1'b0;
      k         <= '0;
    end else begin
      if (adv) begin
        out_valid <= busy;
        if (busy) begin
          k <= (k == KLAST) ? '0 : k + KW'(1);
        end
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (adv && busy && k == KLAST) begin
        busy <= 1'b0;
      end
    end
  end

  `TPU_ASSERT(a_load_shows, clk, rst, (busy && adv) |=> out_valid)

endmodule

// ===== hw/rtl/tracker_pattern_unpacker.sv =====
// Top level of the tracker pattern unpacker: parser, row queue, result sequencer.
// Takes one packed byte per cycle; bytes stall only while the two-entry row queue is full.
// A row-end byte yields OUT_CHANNELS transfers through the row queue, row register and
// output register, one per cycle while m_tready holds; the result side sets the row rate.
// The mask store is a 64-entry RAM whose registered read data is taken up by the next byte.
// Synchronous reset clears the pattern state and sets row_count to 64; no clearing pass.
module tracker_pattern_unpacker #(
  parameter int OUT_CHANNELS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,     // row_count
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // data_byte
  input  logic        s_tuser,      // pattern_start
  output logic        m_tvalid,
  input  logic        m_tready,
  // channel_index[2:0], note_valid, note_value, instr_valid, instr_value,
  // volpan_valid, volpan_value, effect_valid, effect_code, effect_arg, zero pad
  output logic [47:0] m_tdata,
  output logic        m_tlast,      // row_last_channel
  output logic        m_tuser       // pattern_last_row
);
  import tpu_pkg::*;

  localparam int QW = OUT_CHANNELS * $bits(chan_rec_t) + 1;

  logic [15:0]   row_count;
  logic          push, q_full, pop, q_nempty;
  logic [QW-1:0] push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= 16'd64;
    end else if (cfg_we) begin
      row_count <= cfg_data;
    end
  end

  tpu_front #(
    .OUT_CHANNELS (OUT_CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .data_byte     (s_tdata),
    .pattern_start (s_tuser),
    .row_count     (row_count),
    .push          (push),
    .push_data     (push_data),
    .q_full        (q_full)
  );

  tpu_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_nempty)
  );

  tpu_back #(
    .OUT_CHANNELS (OUT_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_data  (pop_data),
    .not_empty (q_nempty),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast),
    .out_user  (m_tuser)
  );

endmodule
